// ----- design/pc1_stream_cipher_byte_macros.svh -----
// Assertion macros shared by the PC1 cipher RTL.
`ifndef PC1_STREAM_CIPHER_BYTE_MACROS_SVH
`define PC1_STREAM_CIPHER_BYTE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PC1_ASSERT_IMPLY(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("pc1 check failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define PC1_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("pc1 check failed: next-cycle implication");

`endif

// ----- design/pc1_pkg.sv -----
// Package: constants, control word types and microcode store of the PC1 cipher.
`timescale 1ns / 1ps

package pc1_pkg;

    localparam logic [15:0] PC1_MUL_P = 16'h015a;
    localparam logic [15:0] PC1_MUL_W = 16'h4e35;

    localparam int KEY_W   = 128;
    localparam int STEP_W  = 4;
    localparam int RND_W   = 3;
    localparam int CFG_IDX_W = 2;

    typedef logic [STEP_W-1:0] step_t;
    typedef logic [RND_W-1:0]  rnd_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // register indexes of the configuration port
    localparam cfg_idx_t REG_KEY_HIGH     = 2'd0;
    localparam cfg_idx_t REG_KEY_LOW      = 2'd1;
    localparam cfg_idx_t REG_DECRYPT_MODE = 2'd2;

    // program layout
    localparam step_t STEP_IDLE       = 4'd0;
    localparam step_t STEP_ROUND0     = 4'd1;
    localparam step_t STEP_ROUND_LAST = 4'd8;
    localparam step_t STEP_FINISH     = 4'd9;

    // condition that keeps the step counter where it is
    typedef enum logic [1:0] {
        HC_NONE,
        HC_NO_INPUT,
        HC_OUT_BUSY
    } hold_cond_t;

    // one microcode word
    typedef struct packed {
        logic       accept;
        logic       round;
        logic       finish;
        rnd_t       rnd_idx;
        hold_cond_t hold_cond;
        step_t      next_step;
    } ucode_t;

    // sequencer to datapath
    typedef struct packed {
        logic accept_fire;
        logic round_en;
        rnd_t rnd_idx;
        logic finish_fire;
    } dp_ctrl_t;

    // datapath to sequencer
    typedef struct packed {
        logic out_busy;
    } dp_stat_t;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w = '{accept: 1'b0, round: 1'b0, finish: 1'b0, rnd_idx: '0,
              hold_cond: HC_NONE, next_step: STEP_IDLE};
        case (step)
            STEP_IDLE:
            begin
                w.accept    = 1'b1;
                w.hold_cond = HC_NO_INPUT;
                w.next_step = STEP_ROUND0;
            end
            STEP_FINISH:
            begin
                w.finish    = 1'b1;
                w.hold_cond = HC_OUT_BUSY;
                w.next_step = STEP_IDLE;
            end
            default:
            begin
                if (step inside {[STEP_ROUND0:STEP_ROUND_LAST]})
                begin
                    w.round     = 1'b1;
                    w.rnd_idx   = RND_W'(step - STEP_ROUND0);
                    w.next_step = (step == STEP_ROUND_LAST) ? STEP_FINISH : step_t'(step + 1'b1);
                end
            end
        endcase
        return w;
    endfunction

endpackage

// ----- design/pc1_seq.sv -----
// Microcode sequencer: step counter, control store lookup and hold conditions.
`timescale 1ns / 1ps

module pc1_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  pc1_pkg::dp_stat_t stat,
    output logic              in_ready,
    output pc1_pkg::dp_ctrl_t ctrl
);

    pc1_pkg::step_t  step_reg;
    pc1_pkg::step_t  step_next;
    pc1_pkg::ucode_t uw;
    logic            hold;

    assign uw = pc1_pkg::ucode_rom(step_reg);

    always_comb
    begin
        case (uw.hold_cond)
            pc1_pkg::HC_NO_INPUT: hold = !in_valid;
            pc1_pkg::HC_OUT_BUSY: hold = stat.out_busy;
            default:              hold = 1'b0;
        endcase
        step_next = hold ? step_reg : uw.next_step;
    end

    assign in_ready         = uw.accept;
    assign ctrl.accept_fire = uw.accept && in_valid;
    assign ctrl.round_en    = uw.round;
    assign ctrl.rnd_idx     = uw.rnd_idx;
    assign ctrl.finish_fire = uw.finish && !stat.out_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= pc1_pkg::STEP_IDLE;
        else
            step_reg <= step_next;
    end

endmodule

// ----- design/pc1_datapath.sv -----
// Datapath: running key, round unit with constant multipliers, output register.
`timescale 1ns / 1ps

module pc1_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pc1_pkg::dp_ctrl_t         ctrl,
    input  logic [7:0]                data_byte,
    input  logic                      start_req,
    input  logic [63:0]               key_high,
    input  logic [63:0]               key_low,
    input  logic                      decrypt_mode,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic [7:0]                out_byte,
    output pc1_pkg::dp_stat_t         stat
);

    logic [pc1_pkg::KEY_W-1:0] key_reg;
    logic [pc1_pkg::KEY_W-1:0] key_next;
    logic [15:0] cs_reg, cs_next;
    logic [15:0] cp_reg, cp_next;
    logic [15:0] prev_reg, prev_next;
    logic [15:0] acc_reg, acc_next;
    logic [7:0]  data_reg;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg;

    logic [15:0] w;
    logic [31:0] prod_p, prod_c, prod_w;
    logic [15:0] cs_plus_j;
    logic [7:0]  result;
    logic [7:0]  feed;

    // round j: keyword sits in the top 16 bits; key rotates by one word per round
    assign w         = key_reg[pc1_pkg::KEY_W-1 -: 16]
                       ^ ((ctrl.rnd_idx == '0) ? 16'h0000 : prev_reg);
    assign cs_plus_j = cs_reg + 16'(ctrl.rnd_idx);
    assign prod_p    = w * pc1_pkg::PC1_MUL_P;
    assign prod_c    = cs_plus_j * pc1_pkg::PC1_MUL_W;
    assign prod_w    = w * pc1_pkg::PC1_MUL_W;

    assign result = data_reg ^ acc_reg[15:8] ^ acc_reg[7:0];
    assign feed   = decrypt_mode ? result : data_reg;

    assign stat.out_busy = out_valid_reg && !out_ready;

    always_comb
    begin
        key_next       = key_reg;
        cs_next        = cs_reg;
        cp_next        = cp_reg;
        prev_next      = prev_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (ctrl.accept_fire)
        begin
            acc_next = 16'h0000;
            if (start_req)
            begin
                key_next = {key_high, key_low};
                cs_next  = 16'h0000;
                cp_next  = 16'h0000;
            end
        end
        if (ctrl.round_en)
        begin
            cs_next   = prod_c[15:0] + prod_p[15:0] + cp_reg;
            cp_next   = prod_p[15:0];
            prev_next = prod_w[15:0] + 16'h0001;
            acc_next  = acc_reg ^ prev_next ^ cs_next;
            key_next  = {key_reg[pc1_pkg::KEY_W-17:0], key_reg[pc1_pkg::KEY_W-1 -: 16]};
        end
        if (ctrl.finish_fire)
        begin
            key_next       = key_reg ^ {(pc1_pkg::KEY_W/8){feed}};
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg       <= '0;
            cs_reg        <= '0;
            cp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            key_reg       <= key_next;
            cs_reg        <= cs_next;
            cp_reg        <= cp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
        acc_reg  <= acc_next;
        if (ctrl.accept_fire)
            data_reg <= data_byte;
        if (ctrl.finish_fire)
            out_byte_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

endmodule

// ----- design/pc1_stream_cipher_byte.sv -----
// Top level of the PC1 byte stream cipher (128-bit key).
`timescale 1ns / 1ps
`include "pc1_stream_cipher_byte_macros.svh"

// PC1 byte cipher, one item in and one item out per byte. An item with
// start_req set reloads the 16-byte running key from key_high/key_low and
// clears the two 16-bit chaining words before it is processed. The result
// register is loaded by the finish step, and a new item is taken only after
// the finish step of the previous one: one accept step, eight round steps on
// a single round unit (three 16x16 constant multipliers, one round per
// cycle), and one finish step that forms out_byte and xors the feedback
// byte into the key. The microcode program sets this order; a stalled
// output holds the finish step.
// The next item is accepted while an earlier result still waits in the
// output register. decrypt_mode picks which byte feeds the key update
// (input when encrypting, output when decrypting). Configuration writes are
// always taken (cfg_ready is tied high); index 3 is ignored. Key writes only
// take effect at the next start item.
module pc1_stream_cipher_byte (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // input items
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        start_req,
    // result items
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte
);

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic        decrypt_mode_reg;
    logic        cfg_fire;

    pc1_pkg::dp_ctrl_t ctrl;
    pc1_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg     <= '0;
            key_low_reg      <= '0;
            decrypt_mode_reg <= 1'b0;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                pc1_pkg::REG_KEY_HIGH:     key_high_reg     <= cfg_data;
                pc1_pkg::REG_KEY_LOW:      key_low_reg      <= cfg_data;
                pc1_pkg::REG_DECRYPT_MODE: decrypt_mode_reg <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    // program sequencer
    pc1_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .in_ready (in_ready),
        .ctrl     (ctrl)
    );

    // round datapath and output register
    pc1_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .data_byte    (data_byte),
        .start_req    (start_req),
        .key_high     (key_high_reg),
        .key_low      (key_low_reg),
        .decrypt_mode (decrypt_mode_reg),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .out_byte     (out_byte),
        .stat         (stat)
    );

    // once an item is taken the block stays busy for the rounds
    `PC1_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready && ctrl.round_en)
    // rounds never overlap with taking a new item
    `PC1_ASSERT_IMPLY(a_round_not_idle, clk, rst_n, ctrl.round_en, !in_ready && !ctrl.finish_fire)
    // a finished byte always shows up at the output
    `PC1_ASSERT_NEXT(a_finish_gives_out, clk, rst_n, ctrl.finish_fire, out_valid)

endmodule
